// ===== src/cbbs_pkg.sv =====
// Package for the command byte button sequencer: report, state and
// configuration types, hat and stick codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbbs_pkg;

  // Hat codes
  localparam logic [1:0] HAT_IDLE = 2'd0;
  localparam logic [1:0] HAT_WEST = 2'd1;
  localparam logic [1:0] HAT_EAST = 2'd2;
  localparam logic [1:0] HAT_TOP  = 2'd3;

  // Stick codes
  localparam logic [1:0] STICK_REST = 2'd0;
  localparam logic [1:0] STICK_LOW  = 2'd1;
  localparam logic [1:0] STICK_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ACTION_GAP = 2'd0;
  localparam logic [1:0] REG_START_WAIT = 2'd1;
  localparam logic [1:0] REG_REPEAT_CNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] ACTION_GAP_RESET = 8'd3;
  localparam logic [7:0] START_WAIT_RESET = 8'd5;
  localparam logic [3:0] REPEAT_CNT_RESET = 4'd2;

  // Spin count that becomes a single reverse spin
  localparam logic [1:0] SPIN_REVERSE = 2'd3;

  // Button, hat and stick content of one report
  typedef struct packed {
    logic [1:0] ry;
    logic [1:0] rx;
    logic [1:0] hat;
    logic       y;
    logic       x;
    logic       l;
    logic       a;
  } report_t;

  typedef struct packed {
    logic [7:0] action_gap;
    logic [7:0] start_wait;
    logic [3:0] repeat_cnt;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        repeats_left;
    report_t           held;
    logic              piece_busy;
    logic              hold_pending;
    logic [1:0]        spins_left;
    logic signed [3:0] moves_left;
    logic [7:0]        wait_left;
  } seq_state_t;

  typedef struct packed {
    logic    taken;
    report_t rpt;
    logic    is_repeat;
  } result_t;

endpackage

`default_nettype wire

// ===== src/cbbs_req_if.sv =====
// Request channel: valid/ready plus an optional command byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cbbs_req_if;
  logic       valid;
  logic       ready;
  logic       byte_present;
  logic [7:0] command_byte;

  modport source (output valid, byte_present, command_byte, input ready);
  modport sink (input valid, byte_present, command_byte, output ready);
endinterface

`default_nettype wire

// ===== src/cbbs_rsp_if.sv =====
// Report channel: valid/ready plus the fields of one controller report.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cbbs_rsp_if;
  logic       valid;
  logic       ready;
  logic       byte_taken;
  logic       press_a;
  logic       press_l;
  logic       press_x;
  logic       press_y;
  logic [1:0] hat_dir;
  logic [1:0] stick_rx;
  logic [1:0] stick_ry;
  logic       is_repeat;

  modport source (output valid, byte_taken, press_a, press_l, press_x, press_y,
                  hat_dir, stick_rx, stick_ry, is_repeat, input ready);
  modport sink (input valid, byte_taken, press_a, press_l, press_x, press_y,
                hat_dir, stick_rx, stick_ry, is_repeat, output ready);
endinterface

`default_nettype wire

// ===== src/cbbs_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cbbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/cbbs_cfg_regs.sv =====
// Configuration register bank for the sequencer.
// Depends on cbbs_pkg and cbbs_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module cbbs_cfg_regs
  import cbbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cbbs_cfg_if.sink    cfg,
  output cfg_t        regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.action_gap <= ACTION_GAP_RESET;
      regs.start_wait <= START_WAIT_RESET;
      regs.repeat_cnt <= REPEAT_CNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ACTION_GAP: regs.action_gap <= cfg.data;
        REG_START_WAIT: regs.start_wait <= cfg.data;
        REG_REPEAT_CNT: regs.repeat_cnt <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cbbs_step.sv =====
// Step logic: one request against the current state gives the report and
// the next state. Purely combinational. Depends on cbbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbbs_step
  import cbbs_pkg::*;
(
  input  wire seq_state_t  cur,
  input  wire cfg_t        regs,
  input  wire logic   byte_present,
  input  wire logic [7:0] command_byte,
  output seq_state_t  nxt,
  output result_t     res
);

  seq_state_t        mid;
  report_t           rpt;
  logic              take;
  logic              direct;
  logic signed [3:0] mag;

  assign take   = byte_present && (cur.repeats_left == 4'd0);
  assign direct = command_byte[7];
  assign mag    = {1'b0, command_byte[2:0]};

  // Byte decode: direct buttons, or load of a new piece command
  always_comb begin
    mid = cur;
    rpt = '0;
    if (take && direct) begin
      rpt.a = command_byte[0];
      if (command_byte[2])      rpt.rx = STICK_HIGH;
      else if (command_byte[1]) rpt.rx = STICK_LOW;
      else                      rpt.rx = STICK_REST;
      if (command_byte[4])      rpt.ry = STICK_HIGH;
      else if (command_byte[3]) rpt.ry = STICK_LOW;
      else                      rpt.ry = STICK_REST;
    end else if (take) begin
      mid.hold_pending = command_byte[6];
      mid.spins_left   = command_byte[5:4];
      mid.moves_left   = command_byte[3] ? -mag : mag;
      mid.wait_left    = regs.start_wait;
      mid.piece_busy   = 1'b1;
    end
  end

  // Piece action sequencing and result
  always_comb begin
    nxt = mid;
    res = '0;
    res.rpt = rpt;
    if (cur.repeats_left != 4'd0) begin
      nxt = cur;
      nxt.repeats_left = cur.repeats_left - 4'd1;
      res.rpt = cur.held;
      res.is_repeat = 1'b1;
    end else begin
      res.taken = take;
      if (mid.piece_busy) begin
        if (mid.wait_left != 8'd0) begin
          nxt.wait_left = mid.wait_left - 8'd1;
        end else begin
          nxt.wait_left = regs.action_gap;
          if (mid.hold_pending) begin
            res.rpt.l = 1'b1;
            nxt.hold_pending = 1'b0;
          end else if (mid.spins_left != 2'd0) begin
            if (mid.spins_left == SPIN_REVERSE) begin
              res.rpt.x = 1'b1;
              nxt.spins_left = 2'd0;
            end else begin
              res.rpt.y = 1'b1;
              nxt.spins_left = mid.spins_left - 2'd1;
            end
          end else if (mid.moves_left > 4'sd0) begin
            res.rpt.hat = HAT_WEST;
            nxt.moves_left = mid.moves_left - 4'sd1;
          end else if (mid.moves_left < 4'sd0) begin
            res.rpt.hat = HAT_EAST;
            nxt.moves_left = mid.moves_left + 4'sd1;
          end else begin
            res.rpt.hat = HAT_TOP;
            nxt.piece_busy = 1'b0;
          end
        end
      end
      nxt.held = res.rpt;
      nxt.repeats_left = regs.repeat_cnt;
    end
  end

endmodule

`default_nettype wire

// ===== src/command_byte_button_sequencer_core.sv =====
// Command byte button sequencer: turns report requests and command bytes
// into controller reports. Three channels, all valid/ready:
//   req - one request per report, optionally offering a command byte.
//   rsp - one report per request, in order, with byte_taken and is_repeat.
//   cfg - register writes (action gap, start wait, repeat count), which the
//         user must make only while no request is outstanding; unchecked here.
// Each request is decoded in the cycle it is accepted and its report lands
// in the output register at that edge, and while rsp is not stalled one
// request can be accepted every cycle. This is set by the single
// step stage feeding the output register.
// req.ready is high while the output register is empty or being emptied
// in the same cycle; a stalled rsp holds its report and blocks further
// requests until it is taken.
// Synchronous reset clears the sequencing state and the output valid and
// loads the register defaults (gap 3, start wait 5, repeats 2). There is
// no clearing pass.
// Depends on cbbs_pkg, the channel interfaces, cbbs_cfg_regs, cbbs_step.
`timescale 1ns / 1ps
`default_nettype none

module command_byte_button_sequencer_core
  import cbbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  cbbs_cfg_if.sink  cfg,
  cbbs_req_if.sink  req,
  cbbs_rsp_if.source rsp
);

  cfg_t       regs;
  seq_state_t state;
  seq_state_t state_next;
  result_t    res_next;
  result_t    res;
  logic       rsp_valid;
  logic       req_fire;

  cbbs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cbbs_step u_step (
    .cur          (state),
    .regs         (regs),
    .byte_present (req.byte_present),
    .command_byte (req.command_byte),
    .nxt          (state_next),
    .res          (res_next)
  );

  // Accept while the output register is free or draining
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  // Sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (req_fire) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.byte_taken = res.taken;
  assign rsp.press_a    = res.rpt.a;
  assign rsp.press_l    = res.rpt.l;
  assign rsp.press_x    = res.rpt.x;
  assign rsp.press_y    = res.rpt.y;
  assign rsp.hat_dir    = res.rpt.hat;
  assign rsp.stick_rx   = res.rpt.rx;
  assign rsp.stick_ry   = res.rpt.ry;
  assign rsp.is_repeat  = res.is_repeat;

`ifndef SYNTHESIS
  // A repeat never consumes a byte
  a_repeat_no_take: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && res.is_repeat |-> !res.taken)
    else $error("repeat report consumed a byte");

  // Pending repeats make the next report a repeat
  a_repeat_follows: assert property (@(posedge clk) disable iff (rst)
    req_fire && (state.repeats_left != 4'd0) |=> rsp_valid && res.is_repeat)
    else $error("pending repeat not issued");

  // At most one piece action button per report
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones({res.rpt.l, res.rpt.x, res.rpt.y}) <= 1)
    else $error("more than one piece action in a report");
`endif

endmodule

`default_nettype wire
